>>> design/uer_pkg.sv
// Shared types, codes and constants of the ultrasonic echo ranger.
package uer_pkg;

  // Counter and arithmetic widths.
  localparam int COUNT_WIDTH = 32;
  localparam int PHASE_W     = 24;
  localparam int TRIG_W      = 16;
  localparam int TICK_NS_W   = 10;
  localparam int NS_MM_W     = 16;
  localparam int PROD_W      = COUNT_WIDTH + TICK_NS_W;
  localparam int DIST_W      = 16;
  localparam int M_W         = 7;
  localparam int UM_W        = 20;
  localparam int REM_W       = 10;

  localparam logic [PHASE_W-1:0]     PHASE_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] ECHO_MAX  = '1;
  localparam logic [DIST_W-1:0]      DIST_MAX  = '1;

  // Split of millimetres into metres and micrometres.
  // Quotient estimate is (d * 1048) >> 20, which is floor(d / 1000) or one less.
  localparam int                 RECIP_SHIFT   = 20;
  localparam int                 SPLIT_PROD_W  = DIST_W + 11;
  localparam logic [10:0]        RECIP_1000    = 11'd1048;
  localparam logic [DIST_W:0]    MM_PER_M      = (DIST_W + 1)'(1000);
  localparam logic [UM_W-1:0]    UM_PER_MM     = UM_W'(1000);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_TICKS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_NS            = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NS_PER_MM          = 3'd4;

  // Register values after reset.
  localparam logic [TRIG_W-1:0]    RST_TRIGGER_TICKS      = 16'd50;
  localparam logic [PHASE_W-1:0]   RST_ECHO_TIMEOUT_TICKS = 24'd60000;
  localparam logic [PHASE_W-1:0]   RST_STARTUP_TICKS      = 24'd100000;
  localparam logic [TICK_NS_W-1:0] RST_TICK_NS            = 10'd1000;
  localparam logic [NS_MM_W-1:0]   RST_NS_PER_MM          = 16'd5831;

  // Power request codes; the unused code changes no power state, but a measure request beside it is rejected.
  localparam logic [1:0] PWR_NONE = 2'd0;
  localparam logic [1:0] PWR_ON   = 2'd1;
  localparam logic [1:0] PWR_OFF  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
  localparam logic [1:0] STATUS_REJECT  = 2'd2;

  // Sensor operating mode.
  typedef enum logic [2:0] {
    MODE_OFF,
    MODE_POWERUP,
    MODE_READY,
    MODE_TRIGGER,
    MODE_WAIT_START,
    MODE_WAIT_END
  } mode_t;

  // Distance conversion sequence.
  typedef enum logic [2:0] {
    SEQ_RUN,
    SEQ_MUL,
    SEQ_DSTART,
    SEQ_DIV,
    SEQ_SPLIT1,
    SEQ_SPLIT2,
    SEQ_SPLIT3,
    SEQ_PUSH
  } seq_t;

  typedef struct packed {
    logic       measure_request;
    logic [1:0] power_request;
    logic       echo_level;
  } in_item_t;

  typedef struct packed {
    logic              trigger_level;
    logic              supply_level;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        status;
    logic [DIST_W-1:0] distance_mm;
    logic [M_W-1:0]    distance_m;
    logic [UM_W-1:0]   distance_um;
  } out_item_t;

  // Flag part of a result item, produced by the controller.
  typedef struct packed {
    logic       trigger_level;
    logic       supply_level;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } res_flags_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic sample;
    logic phase_clear;
    logic phase_tick;
    logic echo_clear;
    logic echo_tick;
    logic mul_load;
    logic div_start;
    logic dist_load;
    logic split_a;
    logic split_b;
    logic split_c;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic echo_edge;
    logic startup_hit;
    logic trig_hit;
    logic timeout_hit;
    logic div_busy;
  } dp_status_t;

endpackage

>>> design/uer_div.sv
// Bit-serial restoring divider for the echo time to distance conversion.
module uer_div import uer_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PROD_W-1:0]  dividend,
  input  logic [NS_MM_W-1:0] divisor,
  output logic               busy,
  output logic [PROD_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(PROD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W - 1);

  logic [NS_MM_W-1:0] rem;
  logic [NS_MM_W-1:0] div_q;
  logic [PROD_W-1:0]  quo;
  logic [STEP_W-1:0]  step;
  logic [NS_MM_W:0]   rem_sh;
  logic [NS_MM_W:0]   diff;
  logic               fits;

  // One quotient bit per cycle, most significant first.
  assign rem_sh = {rem, quo[PROD_W-1]};
  assign diff   = rem_sh - {1'b0, div_q};
  assign fits   = rem_sh >= {1'b0, div_q};

  // Control: busy flag and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dividend;
      div_q <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[NS_MM_W-1:0] : rem_sh[NS_MM_W-1:0];
      quo <= {quo[PROD_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

>>> design/uer_dp.sv
// Datapath: configuration registers, tick counters, echo edge detection and distance conversion.
module uer_dp import uer_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  input  logic                  echo_level,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output dp_status_t            stat,
  output logic [DIST_W-1:0]     distance_mm,
  output logic [M_W-1:0]        distance_m,
  output logic [UM_W-1:0]       distance_um
);

  logic [TRIG_W-1:0]      trigger_ticks;
  logic [PHASE_W-1:0]     echo_timeout_ticks;
  logic [PHASE_W-1:0]     startup_ticks;
  logic [TICK_NS_W-1:0]   tick_ns;
  logic [NS_MM_W-1:0]     ns_per_mm;

  logic [PHASE_W-1:0]     phase_counter;
  logic [PHASE_W-1:0]     phase_inc;
  logic [COUNT_WIDTH-1:0] echo_ticks;
  logic [COUNT_WIDTH-1:0] echo_inc;
  logic                   echo_previous;
  logic [TRIG_W-1:0]      trig_len;
  logic [NS_MM_W-1:0]     divisor;

  logic [PROD_W-1:0]      prod;
  logic                   div_busy;
  logic [PROD_W-1:0]      quotient;
  logic [DIST_W-1:0]      dist_sat;

  logic [M_W-1:0]          q_est;
  logic [REM_W-1:0]        rem_mm;
  logic [SPLIT_PROD_W-1:0] recip_prod;
  logic [DIST_W:0]         q_scaled;
  logic [DIST_W:0]         rem_raw;
  logic [DIST_W:0]         rem_fix;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks      <= RST_TRIGGER_TICKS;
      echo_timeout_ticks <= RST_ECHO_TIMEOUT_TICKS;
      startup_ticks      <= RST_STARTUP_TICKS;
      tick_ns            <= RST_TICK_NS;
      ns_per_mm          <= RST_NS_PER_MM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIGGER_TICKS:      trigger_ticks      <= cfg_data[TRIG_W-1:0];
        CFG_ECHO_TIMEOUT_TICKS: echo_timeout_ticks <= cfg_data[PHASE_W-1:0];
        CFG_STARTUP_TICKS:      startup_ticks      <= cfg_data[PHASE_W-1:0];
        CFG_TICK_NS:            tick_ns            <= cfg_data[TICK_NS_W-1:0];
        CFG_NS_PER_MM:          ns_per_mm          <= cfg_data[NS_MM_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturating increments and threshold compares on the counted value.
  assign phase_inc = (phase_counter == PHASE_MAX) ? phase_counter : phase_counter + 1'b1;
  assign echo_inc  = (echo_ticks == ECHO_MAX) ? echo_ticks : echo_ticks + 1'b1;
  assign trig_len  = (trigger_ticks == '0) ? TRIG_W'(1) : trigger_ticks;
  assign divisor   = (ns_per_mm == '0) ? NS_MM_W'(1) : ns_per_mm;

  assign stat.echo_edge   = echo_level != echo_previous;
  assign stat.startup_hit = phase_inc >= startup_ticks;
  assign stat.trig_hit    = phase_inc >= PHASE_W'(trig_len);
  assign stat.timeout_hit = phase_inc >= echo_timeout_ticks;
  assign stat.div_busy    = div_busy;

  // Tick counters and echo level history.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_counter <= '0;
      echo_ticks    <= '0;
      echo_previous <= 1'b0;
    end else begin
      if (cmd.phase_clear) begin
        phase_counter <= '0;
      end else if (cmd.phase_tick) begin
        phase_counter <= phase_inc;
      end
      if (cmd.echo_clear) begin
        echo_ticks <= '0;
      end else if (cmd.echo_tick) begin
        echo_ticks <= echo_inc;
      end
      if (cmd.sample) begin
        echo_previous <= echo_level;
      end
    end
  end

  // Echo time in nanoseconds.
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= PROD_W'(echo_ticks) * PROD_W'(tick_ns);
    end
  end

  uer_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign dist_sat = (|quotient[PROD_W-1:DIST_W]) ? DIST_MAX : quotient[DIST_W-1:0];

  // Metre and micrometre split, one step per command.
  assign recip_prod = SPLIT_PROD_W'(distance_mm) * SPLIT_PROD_W'(RECIP_1000);
  assign q_scaled   = (DIST_W + 1)'(q_est) * MM_PER_M;
  assign rem_raw    = {1'b0, distance_mm} - q_scaled;
  assign rem_fix    = rem_raw - MM_PER_M;

  always_ff @(posedge clk) begin
    if (cmd.split_a) begin
      q_est <= recip_prod[SPLIT_PROD_W-1:RECIP_SHIFT];
    end
    if (cmd.split_b) begin
      rem_mm <= (rem_raw >= MM_PER_M) ? rem_fix[REM_W-1:0] : rem_raw[REM_W-1:0];
    end
  end

  // Last measured distance in its three forms.
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_mm <= '0;
      distance_m  <= '0;
      distance_um <= '0;
    end else begin
      if (cmd.dist_load) begin
        distance_mm <= dist_sat;
      end
      if (cmd.split_b) begin
        distance_m <= (rem_raw >= MM_PER_M) ? q_est + 1'b1 : q_est;
      end
      if (cmd.split_c) begin
        distance_um <= UM_W'(rem_mm) * UM_PER_MM;
      end
    end
  end

endmodule

>>> design/uer_ctrl.sv
// Controller: sensor mode state machine and distance conversion sequencer.
module uer_ctrl import uer_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  in_item_t   item,
  input  dp_status_t stat,
  output dp_cmd_t    cmd,
  output logic       idle,
  output logic       push,
  output res_flags_t push_flags
);

  mode_t      mode;
  mode_t      mode_next;
  seq_t       seq;
  seq_t       seq_next;
  res_flags_t held;
  res_flags_t held_next;
  res_flags_t imm_flags;
  logic       done;
  logic [1:0] status;
  logic       conv;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_OFF;
      seq  <= SEQ_RUN;
    end else begin
      mode <= mode_next;
      seq  <= seq_next;
    end
  end

  // Flags of a result whose distance comes out of the conversion.
  always_ff @(posedge clk) begin
    held <= held_next;
  end

  // Next state, datapath commands and result flags.
  always_comb begin
    mode_next  = mode;
    seq_next   = seq;
    held_next  = held;
    cmd        = '0;
    done       = 1'b0;
    status     = STATUS_OK;
    conv       = 1'b0;
    push       = 1'b0;
    imm_flags  = '0;
    push_flags = held;

    unique case (seq)
      SEQ_RUN: begin
        if (in_fire) begin
          cmd.sample = 1'b1;
          if (item.power_request == PWR_OFF) begin
            mode_next       = MODE_OFF;
            cmd.phase_clear = 1'b1;
            done            = 1'b1;
          end else if (item.power_request == PWR_ON) begin
            if (mode == MODE_OFF) begin
              mode_next       = MODE_POWERUP;
              cmd.phase_clear = 1'b1;
            end else begin
              done = 1'b1;
            end
          end else if (item.measure_request && mode == MODE_READY) begin
            mode_next       = MODE_TRIGGER;
            cmd.phase_clear = 1'b1;
          end else begin
            unique case (mode)
              MODE_POWERUP: begin
                cmd.phase_tick = 1'b1;
                if (stat.startup_hit) begin
                  mode_next = MODE_READY;
                  done      = 1'b1;
                end
              end
              MODE_TRIGGER: begin
                cmd.phase_tick = 1'b1;
                if (stat.trig_hit) begin
                  mode_next       = MODE_WAIT_START;
                  cmd.phase_clear = 1'b1;
                end
              end
              MODE_WAIT_START: begin
                cmd.phase_tick = 1'b1;
                if (stat.echo_edge) begin
                  mode_next      = MODE_WAIT_END;
                  cmd.echo_clear = 1'b1;
                end
                if (stat.timeout_hit) begin
                  mode_next = MODE_READY;
                  done      = 1'b1;
                  status    = STATUS_TIMEOUT;
                end
              end
              MODE_WAIT_END: begin
                cmd.phase_tick = 1'b1;
                cmd.echo_tick  = 1'b1;
                if (stat.echo_edge) begin
                  mode_next = MODE_READY;
                  done      = 1'b1;
                  conv      = 1'b1;
                end else if (stat.timeout_hit) begin
                  mode_next = MODE_READY;
                  done      = 1'b1;
                  status    = STATUS_TIMEOUT;
                end
              end
              default: ;
            endcase
          end

          // A measure request is rejected unless it comes in the ready mode with no power request.
          if (item.measure_request &&
              !(item.power_request == PWR_NONE && mode == MODE_READY)) begin
            done   = 1'b1;
            status = STATUS_REJECT;
          end

          imm_flags.trigger_level = mode_next == MODE_TRIGGER;
          imm_flags.supply_level  = mode_next != MODE_OFF;
          imm_flags.busy_res      = mode_next == MODE_POWERUP || mode_next == MODE_TRIGGER ||
                                    mode_next == MODE_WAIT_START ||
                                    mode_next == MODE_WAIT_END;
          imm_flags.done_res      = done;
          imm_flags.status        = status;

          if (conv) begin
            held_next = imm_flags;
            seq_next  = SEQ_MUL;
          end else begin
            push       = 1'b1;
            push_flags = imm_flags;
          end
        end
      end
      SEQ_MUL: begin
        cmd.mul_load = 1'b1;
        seq_next     = SEQ_DSTART;
      end
      SEQ_DSTART: begin
        cmd.div_start = 1'b1;
        seq_next      = SEQ_DIV;
      end
      SEQ_DIV: begin
        if (!stat.div_busy) begin
          cmd.dist_load = 1'b1;
          seq_next      = SEQ_SPLIT1;
        end
      end
      SEQ_SPLIT1: begin
        cmd.split_a = 1'b1;
        seq_next    = SEQ_SPLIT2;
      end
      SEQ_SPLIT2: begin
        cmd.split_b = 1'b1;
        seq_next    = SEQ_SPLIT3;
      end
      SEQ_SPLIT3: begin
        cmd.split_c = 1'b1;
        seq_next    = SEQ_PUSH;
      end
      SEQ_PUSH: begin
        push     = 1'b1;
        seq_next = SEQ_RUN;
      end
      default: seq_next = SEQ_RUN;
    endcase
  end

  assign idle = seq == SEQ_RUN;

endmodule

>>> design/ultrasonic_echo_ranger_unit.sv
// Top level of the ultrasonic echo ranger: controller, datapath and output buffer.
//
//   channel   direction   handshake            payload
//   in        input       in_valid/in_ready    in_item (one tick of requests and echo level)
//   out       output      out_valid/out_ready  out_item (pins, status, last distance)
//   cfg       input       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item is taken per cycle while the controller is idle and the output buffer has room;
// its result item is registered into the output buffer. An item that ends a measurement
// on the second echo edge holds the input while the bit-serial divider (one bit per cycle
// over 42 bits) and the metre split finish; the result follows then.
// Reset (rst, synchronous) restores register defaults and the off mode.
// A two-entry output buffer keeps the input open while one result waits to be taken.
module ultrasonic_echo_ranger_unit import uer_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int OBUF_DEPTH = 2;
  localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

  logic                  in_fire;
  logic                  pop;
  logic                  idle;
  logic                  push;
  res_flags_t            push_flags;
  dp_cmd_t               cmd;
  dp_status_t            stat;
  logic [DIST_W-1:0]     distance_mm;
  logic [M_W-1:0]        distance_m;
  logic [UM_W-1:0]       distance_um;
  out_item_t             push_item;

  out_item_t             obuf [OBUF_DEPTH];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [OBUF_CNT_W-1:0] obuf_cnt;

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign in_ready  = idle && (obuf_cnt != OBUF_CNT_W'(OBUF_DEPTH));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = obuf_cnt != '0;
  assign pop       = out_valid && out_ready;

  uer_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .item       (in_item),
    .stat       (stat),
    .cmd        (cmd),
    .idle       (idle),
    .push       (push),
    .push_flags (push_flags)
  );

  uer_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .echo_level  (in_item.echo_level),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .stat        (stat),
    .distance_mm (distance_mm),
    .distance_m  (distance_m),
    .distance_um (distance_um)
  );

  // Assemble the result item from controller flags and datapath distance.
  always_comb begin
    push_item.trigger_level = push_flags.trigger_level;
    push_item.supply_level  = push_flags.supply_level;
    push_item.busy_res      = push_flags.busy_res;
    push_item.done_res      = push_flags.done_res;
    push_item.status        = push_flags.status;
    push_item.distance_mm   = distance_mm;
    push_item.distance_m    = distance_m;
    push_item.distance_um   = distance_um;
  end

  // Output buffer pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      obuf_cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        obuf_cnt <= obuf_cnt + 1'b1;
      end else if (pop && !push) begin
        obuf_cnt <= obuf_cnt - 1'b1;
      end
    end
  end

  // Output buffer storage.
  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr] <= push_item;
    end
  end

  assign out_item = obuf[rd_ptr];

endmodule
